[rtl/modbus_response_checker_defines.svh]
// Assertion macros for the Modbus response checker.
// Used by the port-level checker; needs i_clk and i_rst_n in scope.
`ifndef MODBUS_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RESPONSE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mrc_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the Modbus response checker.
// No dependencies.
`default_nettype none

package mrc_pkg;

    // Frame length default and position counter width
    localparam int FRAME_LEN_DEF = 7;
    localparam int POS_W         = 3;

    // Item kinds
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_LINK = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FRAME = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_LINK  = 3'd3;
    localparam logic [2:0] ST_LOST  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ADDR    = 2'd0;
    localparam logic [1:0] CFG_FUNC    = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_ADDR    = 8'd1;
    localparam logic [7:0]  RST_FUNC    = 8'd3;
    localparam logic [7:0]  RST_COUNT   = 8'd2;
    localparam logic [15:0] RST_TIMEOUT = 16'd1000;

    // Header byte positions and distance byte positions
    localparam logic [POS_W-1:0] POS_ADDR  = 3'd0;
    localparam logic [POS_W-1:0] POS_FUNC  = 3'd1;
    localparam logic [POS_W-1:0] POS_COUNT = 3'd2;
    localparam logic [POS_W-1:0] POS_DIST_HI = 3'd3;
    localparam logic [POS_W-1:0] POS_DIST_LO = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic        done;
        logic [2:0]  status;
        logic [15:0] distance;
    } t_frame_res;

    typedef struct packed {
        logic lost;
        logic fault;
    } t_fault_res;

    // Reflected CRC-16, one byte: eight shift/xor steps
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/modbus_response_checker.sv]
// Modbus RTU response checker top level: input register, frame tracker,
// fault monitor and result register. Depends on mrc_pkg, mrc_frame, mrc_fault.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------
//  in       | sink      | i_in_valid / o_in_ready | i_func, i_rx_byte, i_frame_start
//  out      | source    | o_out_valid/i_out_ready | o_status, o_distance, o_comm_fault
//  cfg      | sink      | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken. Each transfer lands in an
// input register and is processed from there into the result register.
// The result register is the only stall point: while it holds an untaken result the
// input register can still take one item, then o_in_ready drops.
// Synchronous active-low reset; no clearing pass, ready right out of reset.
`default_nettype none

module modbus_response_checker #(
    parameter int FRAME_LEN = mrc_pkg::FRAME_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_start,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_distance,
    output logic             o_comm_fault,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [7:0]  r_exp_addr, r_exp_func, r_exp_count;
    logic [15:0] r_timeout;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [7:0]  r_byte;
    logic        r_start;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_distance, n_distance;
    logic        r_fault_out, n_fault_out;
    logic        n_has_res;

    logic        fire;
    logic        is_byte, is_tick, is_link;

    mrc_pkg::t_frame_res frame_res;
    mrc_pkg::t_fault_res fault_res;

    // Process the held item whenever the result slot is free or being emptied
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    assign is_byte = fire && (r_func == mrc_pkg::FUNC_BYTE);
    assign is_tick = fire && (r_func == mrc_pkg::FUNC_TICK);
    assign is_link = fire && (r_func == mrc_pkg::FUNC_LINK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr  <= mrc_pkg::RST_ADDR;
            r_exp_func  <= mrc_pkg::RST_FUNC;
            r_exp_count <= mrc_pkg::RST_COUNT;
            r_timeout   <= mrc_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mrc_pkg::CFG_ADDR:    r_exp_addr  <= i_cfg_data[7:0];
                mrc_pkg::CFG_FUNC:    r_exp_func  <= i_cfg_data[7:0];
                mrc_pkg::CFG_COUNT:   r_exp_count <= i_cfg_data[7:0];
                mrc_pkg::CFG_TIMEOUT: r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func  <= i_func;
            r_byte  <= i_rx_byte;
            r_start <= i_frame_start;
        end
    end

    mrc_frame #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (is_byte),
        .i_link        (is_link),
        .i_rx_byte     (r_byte),
        .i_frame_start (r_start),
        .i_exp_addr    (r_exp_addr),
        .i_exp_func    (r_exp_func),
        .i_exp_count   (r_exp_count),
        .o_res         (frame_res)
    );

    mrc_fault u_fault (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (is_tick),
        .i_frame_done (is_byte && frame_res.done),
        .i_frame_good (frame_res.status == mrc_pkg::ST_OK),
        .i_link       (is_link),
        .i_timeout    (r_timeout),
        .o_res        (fault_res)
    );

    // Result select; the three item kinds are exclusive.
    // Unused kind code falls through with no result.
    always_comb begin
        n_has_res   = 1'b0;
        n_status    = mrc_pkg::ST_OK;
        n_distance  = 16'h0000;
        n_fault_out = fault_res.fault;
        if (is_link) begin
            n_has_res = 1'b1;
            n_status  = mrc_pkg::ST_LINK;
        end else if (is_tick) begin
            n_has_res = fault_res.lost;
            n_status  = mrc_pkg::ST_LOST;
        end else if (is_byte) begin
            n_has_res  = frame_res.done;
            n_status   = frame_res.status;
            n_distance = frame_res.distance;
        end
        n_out_valid = fire ? n_has_res : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_has_res) begin
            r_status    <= n_status;
            r_distance  <= n_distance;
            r_fault_out <= n_fault_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_distance   = r_distance;
    assign o_comm_fault = r_fault_out;

endmodule

`default_nettype wire

[rtl/mrc_frame.sv]
// Frame tracker: byte position, header check, CRC accumulation, distance capture.
// Depends on mrc_pkg.
`default_nettype none

module mrc_frame #(
    parameter int FRAME_LEN = mrc_pkg::FRAME_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_link,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_frame_start,
    input  wire logic [7:0]        i_exp_addr,
    input  wire logic [7:0]        i_exp_func,
    input  wire logic [7:0]        i_exp_count,
    output mrc_pkg::t_frame_res    o_res
);

    localparam logic [mrc_pkg::POS_W-1:0] POS_CRC_LO = mrc_pkg::POS_W'(FRAME_LEN - 2);
    localparam logic [mrc_pkg::POS_W-1:0] POS_LAST   = mrc_pkg::POS_W'(FRAME_LEN - 1);

    logic [mrc_pkg::POS_W-1:0] r_pos, n_pos, pos_eff;
    logic [15:0]               r_crc, n_crc, crc_eff, crc_fed;
    logic                      r_hdr, n_hdr, hdr_eff;
    logic [15:0]               r_dist, n_dist;
    logic [7:0]                r_crc_lo, n_crc_lo;
    logic                      done;
    logic [15:0]               rx_crc;

    // A start flag restarts the frame on this very byte
    always_comb begin
        pos_eff = i_frame_start ? '0 : r_pos;
        crc_eff = i_frame_start ? mrc_pkg::CRC_INIT : r_crc;
        hdr_eff = i_frame_start ? 1'b1 : r_hdr;

        n_hdr = hdr_eff;
        if (pos_eff == mrc_pkg::POS_ADDR  && i_rx_byte != i_exp_addr)  n_hdr = 1'b0;
        if (pos_eff == mrc_pkg::POS_FUNC  && i_rx_byte != i_exp_func)  n_hdr = 1'b0;
        if (pos_eff == mrc_pkg::POS_COUNT && i_rx_byte != i_exp_count) n_hdr = 1'b0;

        crc_fed = mrc_pkg::crc16_feed(crc_eff, i_rx_byte);
        n_crc   = (pos_eff < POS_CRC_LO) ? crc_fed : crc_eff;

        n_dist = r_dist;
        if (pos_eff == mrc_pkg::POS_DIST_HI) n_dist[15:8] = i_rx_byte;
        if (pos_eff == mrc_pkg::POS_DIST_LO) n_dist[7:0]  = i_rx_byte;

        n_crc_lo = (pos_eff == POS_CRC_LO) ? i_rx_byte : r_crc_lo;

        done   = (pos_eff >= POS_LAST);
        rx_crc = {i_rx_byte, r_crc_lo};
        n_pos  = pos_eff + 1'b1;

        o_res.done     = done;
        o_res.distance = 16'h0000;
        if (!n_hdr) begin
            o_res.status = mrc_pkg::ST_FRAME;
        end else if (rx_crc != crc_eff) begin
            o_res.status = mrc_pkg::ST_CRC;
        end else begin
            o_res.status   = mrc_pkg::ST_OK;
            o_res.distance = n_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= mrc_pkg::CRC_INIT;
            r_hdr    <= 1'b1;
            r_dist   <= 16'h0000;
            r_crc_lo <= 8'h00;
        end else if (i_link) begin
            r_pos <= '0;
            r_crc <= mrc_pkg::CRC_INIT;
            r_hdr <= 1'b1;
        end else if (i_step) begin
            r_dist   <= n_dist;
            r_crc_lo <= n_crc_lo;
            if (done) begin
                r_pos <= '0;
                r_crc <= mrc_pkg::CRC_INIT;
                r_hdr <= 1'b1;
            end else begin
                r_pos <= n_pos;
                r_crc <= n_crc;
                r_hdr <= n_hdr;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/mrc_fault.sv]
// Communication-fault monitor: saturating tick counter and fault flag.
// Depends on mrc_pkg.
`default_nettype none

module mrc_fault (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_tick,
    input  wire logic           i_frame_done,
    input  wire logic           i_frame_good,
    input  wire logic           i_link,
    input  wire logic [15:0]    i_timeout,
    output mrc_pkg::t_fault_res o_res
);

    logic [15:0] r_ticks, n_ticks, ticks_inc;
    logic        r_fault, n_fault;
    logic        over;

    always_comb begin
        ticks_inc = (r_ticks != mrc_pkg::TICK_MAX) ? r_ticks + 16'd1 : r_ticks;
        over      = (ticks_inc > i_timeout);
        n_ticks   = r_ticks;
        n_fault   = r_fault;
        if (i_tick) begin
            n_ticks = ticks_inc;
            if (over) n_fault = 1'b1;
        end else if (i_frame_done) begin
            if (i_frame_good) begin
                n_ticks = 16'h0000;
                n_fault = 1'b0;
            end else begin
                n_fault = 1'b1;
            end
        end else if (i_link) begin
            n_fault = 1'b1;
        end
        // lost only on the clear-to-set edge of the flag from a tick
        o_res.lost  = i_tick && over && !r_fault;
        o_res.fault = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= 16'h0000;
            r_fault <= 1'b1;
        end else begin
            r_ticks <= n_ticks;
            r_fault <= n_fault;
        end
    end

endmodule

`default_nettype wire

[rtl/mrc_checker.sv]
// Port-level checker for the Modbus response checker, bound to the top level.
// Depends on mrc_pkg and modbus_response_checker_defines.svh.
`default_nettype none
`include "modbus_response_checker_defines.svh"

module mrc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_distance,
    input wire logic        o_comm_fault
);

    // stalled result holds
    `MRC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_distance) && $stable(o_comm_fault), "stalled result changed")

    // a good frame always clears the fault flag
    `MRC_ASSERT_NOW(a_ok_clears, o_out_valid && o_status == mrc_pkg::ST_OK, !o_comm_fault, "ok result with fault flag set")

    // every error result carries the fault flag and no distance
    `MRC_ASSERT_NOW(a_err_fault, o_out_valid && o_status != mrc_pkg::ST_OK, o_comm_fault && o_distance == 16'h0000, "error result without fault or with distance")

    // empty result slot never blocks the input
    `MRC_ASSERT_NOW(a_ready_free, !o_out_valid, o_in_ready, "input stalled with empty result slot")

endmodule

bind modbus_response_checker mrc_checker u_mrc_checker (.*);

`default_nettype wire

[tb/sv/modbus_response_checker_tb.sv]
// Testbench for modbus_response_checker: drives response bytes, time ticks and link
// failures over valid/ready, predicts each status with its own frame/CRC model and
// checks every result transfer field by field. Depends on mrc_pkg and the RTL top.
module modbus_response_checker_tb;

    localparam int         FLEN         = mrc_pkg::FRAME_LEN_DEF;
    localparam logic [1:0] FUNC_SPARE   = 2'd3;       // unused item kind, block ignores it
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 6;
    localparam int         MAX_REPORTS  = 10;
    localparam int         PHASE_ITEMS  = 128;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] distance;
        logic        comm_fault;
    } t_response;

    // DUT ports, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func        = mrc_pkg::FUNC_BYTE;
    logic [7:0]  i_rx_byte     = 8'h00;
    logic        i_frame_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_distance;
    logic        o_comm_fault;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = mrc_pkg::CFG_ADDR;
    logic [15:0] i_cfg_data    = 16'h0000;

    // Predictor copy of the configuration (reset values)
    logic [7:0]  exp_addr      = mrc_pkg::RST_ADDR;
    logic [7:0]  exp_func      = mrc_pkg::RST_FUNC;
    logic [7:0]  exp_count     = mrc_pkg::RST_COUNT;
    logic [15:0] timeout_limit = mrc_pkg::RST_TIMEOUT;

    // Predictor copy of the frame tracker and fault monitor (reset values)
    logic [2:0]  byte_pos      = 3'd0;
    logic [15:0] crc_run       = mrc_pkg::CRC_INIT;
    logic        header_ok     = 1'b1;
    logic [15:0] dist_latch    = 16'h0000;
    logic [7:0]  crc_lo_latch  = 8'h00;
    logic [15:0] tick_count    = 16'h0000;
    logic        fault_state   = 1'b1;

    t_response   expected_responses[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;

    // Sender / receiver pacing
    bit          tx_idle        = 1'b1;
    bit          rx_stalls      = 1'b1;
    int          rx_hold_req    = 0;
    int          rx_hold_left   = 0;
    int          rx_stall_left  = 0;

    modbus_response_checker #(
        .FRAME_LEN(FLEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_distance    (o_distance),
        .o_comm_fault  (o_comm_fault),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Reflected CRC-16, bit-serial, LSB of the byte first
    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ mrc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void restart_frame();
        byte_pos  = 3'd0;
        crc_run   = mrc_pkg::CRC_INIT;
        header_ok = 1'b1;
    endfunction

    // Result carries the fault flag as it stands after the item
    function automatic void queue_response(logic [2:0] st, logic [15:0] mm);
        t_response r;
        r.status     = st;
        r.distance   = mm;
        r.comm_fault = fault_state;
        expected_responses.push_back(r);
    endfunction

    task automatic predict_response(logic [1:0] func, logic [7:0] data, logic start);
        logic [2:0] pos;
        logic       was_faulted;
        logic [2:0] st;
        case (func)
            mrc_pkg::FUNC_TICK: begin
                was_faulted = fault_state;
                if (tick_count != mrc_pkg::TICK_MAX) begin
                    tick_count = tick_count + 16'd1;
                end
                if (tick_count > timeout_limit) begin
                    fault_state = 1'b1;
                    // only the clear-to-set edge reports comm lost
                    if (!was_faulted) begin
                        queue_response(mrc_pkg::ST_LOST, 16'h0000);
                    end
                end
            end
            mrc_pkg::FUNC_LINK: begin
                restart_frame();
                fault_state = 1'b1;
                queue_response(mrc_pkg::ST_LINK, 16'h0000);
            end
            mrc_pkg::FUNC_BYTE: begin
                if (start) begin
                    restart_frame();
                end
                pos = byte_pos;
                if (pos == mrc_pkg::POS_ADDR && data != exp_addr) header_ok = 1'b0;
                if (pos == mrc_pkg::POS_FUNC && data != exp_func) header_ok = 1'b0;
                if (pos == mrc_pkg::POS_COUNT && data != exp_count) header_ok = 1'b0;
                if (pos < FLEN - 2) begin
                    crc_run = crc16_next(crc_run, data);
                end
                if (pos == mrc_pkg::POS_DIST_HI) dist_latch[15:8] = data;
                if (pos == mrc_pkg::POS_DIST_LO) dist_latch[7:0] = data;
                if (pos == FLEN - 2) crc_lo_latch = data;
                if (pos >= FLEN - 1) begin
                    // header error wins over CRC error
                    if (!header_ok) begin
                        st = mrc_pkg::ST_FRAME;
                    end else if ({data, crc_lo_latch} != crc_run) begin
                        st = mrc_pkg::ST_CRC;
                    end else begin
                        st = mrc_pkg::ST_OK;
                    end
                    if (st == mrc_pkg::ST_OK) begin
                        tick_count  = 16'h0000;
                        fault_state = 1'b0;
                    end else begin
                        fault_state = 1'b1;
                    end
                    restart_frame();
                    queue_response(st, (st == mrc_pkg::ST_OK) ? dist_latch : 16'h0000);
                end else begin
                    byte_pos = pos + 3'd1;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid is left high: the next send keeps it up or drops it for a gap.
    task automatic send_item(logic [1:0] func, logic [7:0] data, logic start);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_rx_byte     <= data;
        i_frame_start <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_response(func, data, start);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, wait until every predicted result is seen, then let the pipe empty
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            mrc_pkg::CFG_ADDR:    exp_addr      = value[7:0];
            mrc_pkg::CFG_FUNC:    exp_func      = value[7:0];
            mrc_pkg::CFG_COUNT:   exp_count     = value[7:0];
            mrc_pkg::CFG_TIMEOUT: timeout_limit = value;
            default: ;
        endcase
    endtask

    // Upper bits of the 8-bit registers carry junk to check they are dropped
    task automatic set_config(logic [7:0] addr, logic [7:0] fn, logic [7:0] cnt,
                              logic [15:0] limit);
        write_cfg(mrc_pkg::CFG_ADDR, {8'($urandom), addr});
        write_cfg(mrc_pkg::CFG_FUNC, {8'($urandom), fn});
        write_cfg(mrc_pkg::CFG_COUNT, {8'($urandom), cnt});
        write_cfg(mrc_pkg::CFG_TIMEOUT, limit);
    endtask

    // Receiver settings change at a rising edge so its falling-edge process sees them cleanly
    task automatic set_receiver(bit stalls, int hold);
        @(posedge i_clk);
        rx_stalls   = stalls;
        rx_hold_req = hold;
        @(negedge i_clk);
    endtask

    // Full response frame; crc_flip corrupts the trailer, noisy mixes ticks and
    // unused items in between the bytes
    task automatic send_frame(logic [7:0] addr, logic [7:0] fn, logic [7:0] cnt,
                              logic [15:0] mm, logic [15:0] crc_flip, logic lead_start,
                              bit noisy);
        logic [7:0]  frame_bytes [FLEN];
        logic [15:0] crc;
        frame_bytes[0] = addr;
        frame_bytes[1] = fn;
        frame_bytes[2] = cnt;
        frame_bytes[3] = mm[15:8];
        frame_bytes[4] = mm[7:0];
        crc = mrc_pkg::CRC_INIT;
        for (int i = 0; i < FLEN - 2; i++) begin
            crc = crc16_next(crc, frame_bytes[i]);
        end
        crc = crc ^ crc_flip;
        frame_bytes[FLEN-2] = crc[7:0];
        frame_bytes[FLEN-1] = crc[15:8];
        for (int i = 0; i < FLEN; i++) begin
            if (noisy && i > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(mrc_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
                end else if ($urandom_range(0, 49) == 0) begin
                    send_item(FUNC_SPARE, 8'($urandom), 1'($urandom));
                end
            end
            send_item(mrc_pkg::FUNC_BYTE, frame_bytes[i], (i == 0) ? lead_start : 1'b0);
        end
    endtask

    task automatic send_good_frame(logic [15:0] mm);
        send_frame(exp_addr, exp_func, exp_count, mm, 16'h0000, 1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or one long hold counted here
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            rx_stall_left = pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_response want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_responses.size() == 0) begin
                report_error($sformatf("%0t: result with none expected: status %0d dist %h fault %0d",
                                       $time, o_status, o_distance, o_comm_fault));
            end else begin
                want = expected_responses.pop_front();
                if (o_status !== want.status || o_distance !== want.distance ||
                    o_comm_fault !== want.comm_fault) begin
                    report_error($sformatf(
                        "%0t: mismatch status exp %0d got %0d, dist exp %h got %h, fault exp %0d got %0d",
                        $time, want.status, o_status, want.distance, o_distance,
                        want.comm_fault, o_comm_fault));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modbus_response_checker_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fault flag is set out of reset, so a tick reports nothing
    task automatic test_reset_state();
        send_item(mrc_pkg::FUNC_TICK, 8'hFF, 1'b1);
    endtask

    // Partial frame dropped by a new frame start; good frame clears the fault
    task automatic test_frame_restart();
        send_item(mrc_pkg::FUNC_BYTE, exp_addr, 1'b1);
        send_item(mrc_pkg::FUNC_BYTE, exp_func, 1'b0);
        send_good_frame(16'hFFFF);
    endtask

    // Bad address together with bad CRC gives frame error; CRC alone gives CRC error
    task automatic test_frame_errors();
        send_frame(~exp_addr, exp_func, exp_count, 16'h0000, 16'h0001, 1'b1, 1'b0);
        send_frame(exp_addr, exp_func, exp_count, 16'h00FF, 16'h8000, 1'b1, 1'b0);
    endtask

    // Unused item kind changes nothing; link failure drops the frame in progress
    task automatic test_link_and_spare();
        send_item(mrc_pkg::FUNC_BYTE, exp_addr, 1'b1);
        send_item(mrc_pkg::FUNC_BYTE, exp_func, 1'b0);
        send_item(FUNC_SPARE, 8'hFF, 1'b1);
        send_item(mrc_pkg::FUNC_LINK, 8'h00, 1'b0);
    endtask

    task automatic test_timeout_expiry();
        // zero timeout: first tick after a good frame trips, second stays quiet
        wait_drain();
        write_cfg(mrc_pkg::CFG_TIMEOUT, 16'h0000);
        send_good_frame(16'h1234);
        send_item(mrc_pkg::FUNC_TICK, 8'h00, 1'b0);
        send_item(mrc_pkg::FUNC_TICK, 8'h00, 1'b0);
        wait_drain();
        write_cfg(mrc_pkg::CFG_TIMEOUT, 16'd3);
        send_good_frame(16'hABCD);
        repeat (4) send_item(mrc_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
        wait_drain();
        write_cfg(mrc_pkg::CFG_TIMEOUT, mrc_pkg::RST_TIMEOUT);
    endtask

    // Max timeout stays quiet over a run of ticks; a lower limit written while the
    // count is already above it trips on the very next tick
    task automatic test_tick_threshold();
        wait_drain();
        write_cfg(mrc_pkg::CFG_TIMEOUT, 16'hFFFF);
        tx_idle = 1'b0;
        set_receiver(1'b0, 0);
        send_good_frame(16'h0F0F);
        repeat (20) send_item(mrc_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
        wait_drain();
        write_cfg(mrc_pkg::CFG_TIMEOUT, 16'd5);
        send_item(mrc_pkg::FUNC_TICK, 8'h00, 1'b0);
        wait_drain();
        tx_idle = 1'b1;
        set_receiver(1'b1, 0);
    endtask

    // Header registers at both extremes and random, each field mismatched alone
    task automatic test_header_config();
        logic [7:0] a, f, c;
        for (int s = 0; s < 3; s++) begin
            case (s)
                0: begin a = 8'h00; f = 8'h00; c = 8'h00; end
                1: begin a = 8'hFF; f = 8'hFF; c = 8'hFF; end
                default: begin a = 8'($urandom); f = 8'($urandom); c = 8'($urandom); end
            endcase
            wait_drain();
            set_config(a, f, c, mrc_pkg::RST_TIMEOUT);
            send_good_frame(16'($urandom));
            send_frame(a ^ 8'($urandom_range(1, 255)), f, c, 16'($urandom), 16'h0000,
                       1'b1, 1'b0);
            send_frame(a, f ^ 8'($urandom_range(1, 255)), c, 16'($urandom), 16'h0000,
                       1'b1, 1'b0);
            send_frame(a, f, c ^ 8'($urandom_range(1, 255)), 16'($urandom), 16'h0000,
                       1'b1, 1'b0);
        end
    endtask

    // Receiver holds off long while the sender keeps pushing: result register
    // and input register fill, then o_in_ready must drop
    task automatic test_backpressure();
        wait_drain();
        tx_idle = 1'b0;
        set_receiver(1'b0, 200);
        repeat (5) send_item(mrc_pkg::FUNC_LINK, 8'($urandom), 1'($urandom));
        send_good_frame(16'h5A5A);
        repeat (5) send_item(mrc_pkg::FUNC_LINK, 8'($urandom), 1'($urandom));
        wait_drain();
        tx_idle = 1'b1;
        set_receiver(1'b1, 0);
    endtask

    // Mostly well-formed frames with random content and occasional corruption,
    // mixed with ticks, link failures, fragments and stray bytes
    task automatic test_random_traffic();
        int          first;
        int          roll;
        bit          paused;
        logic [7:0]  a, f, c;
        logic [15:0] mm;
        logic [15:0] flip;
        int          frag_len;
        paused = 1'b0;
        for (int phase = 0; phase < 6; phase++) begin
            wait_drain();
            if (phase == 5) begin
                set_config(mrc_pkg::RST_ADDR, mrc_pkg::RST_FUNC, mrc_pkg::RST_COUNT,
                           mrc_pkg::RST_TIMEOUT);
            end else begin
                set_config(8'($urandom), 8'($urandom), 8'($urandom),
                           (phase == 4) ? 16'hFFFF : 16'($urandom_range(0, 30)));
            end
            // phase 3 runs with no idling on either side
            tx_idle = (phase != 3);
            set_receiver(phase != 3, 0);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    a = exp_addr;
                    f = exp_func;
                    c = exp_count;
                    case ($urandom_range(0, 11))
                        0: a = a ^ 8'($urandom_range(1, 255));
                        1: f = f ^ 8'($urandom_range(1, 255));
                        2: c = c ^ 8'($urandom_range(1, 255));
                        default: ;
                    endcase
                    case ($urandom_range(0, 7))
                        0: mm = 16'h0000;
                        1: mm = 16'hFFFF;
                        default: mm = 16'($urandom);
                    endcase
                    flip = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0;
                    // a frame may begin without the start flag only when the tracker is idle
                    send_frame(a, f, c, mm, flip, (byte_pos != 3'd0) || $urandom_range(0, 1),
                               1'b1);
                end else if (roll < 78) begin
                    frag_len = $urandom_range(1, FLEN - 1);
                    for (int i = 0; i < frag_len; i++) begin
                        send_item(mrc_pkg::FUNC_BYTE, 8'($urandom), i == 0);
                    end
                end else if (roll < 88) begin
                    send_item(mrc_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
                end else if (roll < 93) begin
                    send_item(mrc_pkg::FUNC_LINK, 8'($urandom), 1'($urandom));
                end else if (roll < 96) begin
                    send_item(FUNC_SPARE, 8'($urandom), 1'($urandom));
                end else begin
                    send_item(mrc_pkg::FUNC_BYTE, 8'($urandom), 1'($urandom));
                end
                // one sender pause mid-phase until everything has come back
                if (phase == 2 && !paused && items_sent - first >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_drain();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_frame_restart();
        test_frame_errors();
        test_link_and_spare();
        test_timeout_expiry();
        test_tick_threshold();
        test_header_config();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("modbus_response_checker_tb: PASS");
        end else begin
            $display("modbus_response_checker_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mrc_pkg.sv
rtl/mrc_frame.sv
rtl/mrc_fault.sv
rtl/modbus_response_checker.sv
rtl/mrc_checker.sv
tb/sv/modbus_response_checker_tb.sv
